### sv/assert_macros.svh
// Assertion macros shared by the brew sequencer RTL.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off while reset is asserted
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, held off while reset is asserted
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

### sv/bsq_pkg.sv
// Package for the brew sequencer: widths, register indexes, phase codes,
// beat payload types and the controller/datapath command and status structs.
// Depends on nothing.
`timescale 1ns / 1ps

package bsq_pkg;

    localparam int TEMP_BITS     = 10;
    localparam int TIME_BITS     = 22;
    localparam int DELTA_BITS    = 10;
    localparam int BREW_BITS     = 20;
    localparam int SLEEP_BITS    = 22;
    localparam int PCT_BITS      = 7;
    localparam int PHASE_BITS    = 3;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 22;
    localparam int CMP_BITS      = (TIME_BITS > SLEEP_BITS) ? TIME_BITS : SLEEP_BITS;
    localparam int NUM_BITS      = BREW_BITS + PCT_BITS;
    localparam int DIV_STEPS     = PCT_BITS;
    localparam int CNT_BITS      = $clog2(DIV_STEPS);

    localparam logic [PCT_BITS-1:0]   PCT_FULL        = PCT_BITS'(100);
    localparam logic [BREW_BITS-1:0]  FILTER_TIME_RST = BREW_BITS'(120000);
    localparam logic [BREW_BITS-1:0]  ESPR_TIME_RST   = BREW_BITS'(30000);
    localparam logic [SLEEP_BITS-1:0] SLEEP_AFTER_RST = SLEEP_BITS'(60000);
    localparam logic [TEMP_BITS-1:0]  PREHEAT_RST     = TEMP_BITS'(600);
    localparam logic [TEMP_BITS-1:0]  BREW_LEVEL_RST  = TEMP_BITS'(700);

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_FILTER_TIME  = 3'd0,
        REG_ESPR_TIME    = 3'd1,
        REG_SLEEP_AFTER  = 3'd2,
        REG_PREHEAT_LVL  = 3'd3,
        REG_BREW_LVL     = 3'd4
    } cfg_reg_t;

    typedef enum logic [PHASE_BITS-1:0] {
        PH_SELECT  = 3'd0,
        PH_ASLEEP  = 3'd1,
        PH_PREHEAT = 3'd2,
        PH_COAST   = 3'd3,
        PH_BREW    = 3'd4
    } phase_t;

    typedef enum logic [1:0] {
        CS_IDLE = 2'd0,
        CS_PREP = 2'd1,
        CS_DIV  = 2'd2,
        CS_PUSH = 2'd3
    } ctl_state_t;

    typedef struct packed {
        logic [DELTA_BITS-1:0] delta_ms;
        logic [TEMP_BITS-1:0]  temp_code;
        logic                  switch_pressed;
        logic                  select_pressed;
    } poll_item_t;

    typedef struct packed {
        logic [PHASE_BITS-1:0] phase;
        logic                  heater_on;
        logic                  pump_on;
        logic                  mode_espresso;
        logic [PCT_BITS-1:0]   progress_pct;
        logic                  brew_done;
    } result_item_t;

    // Controller to datapath
    typedef struct packed {
        logic step;
        logic prep;
        logic div;
        logic push;
    } bsq_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic need_div;
        logic out_free;
    } bsq_stat_t;

endpackage

### sv/bsq_if.sv
// Channel interfaces of the brew sequencer: poll input, result output and
// configuration write. Depends on bsq_pkg.
`timescale 1ns / 1ps

interface bsq_poll_if;
    import bsq_pkg::*;
    logic       valid;
    logic       ready;
    poll_item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface bsq_result_if;
    import bsq_pkg::*;
    logic         valid;
    logic         ready;
    result_item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface bsq_cfg_if;
    import bsq_pkg::*;
    logic                     valid;
    logic                     ready;
    logic [CFG_IDX_BITS-1:0]  index;
    logic [CFG_DATA_BITS-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

### sv/bsq_ctrl.sv
// Controller of the brew sequencer: sequences accept, divider set-up,
// divide steps and result hand-off. Depends on bsq_pkg.
`timescale 1ns / 1ps

module bsq_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              poll_valid,
    output logic              poll_ready,
    input  bsq_pkg::bsq_stat_t stat,
    output bsq_pkg::bsq_cmd_t  cmd
);
    import bsq_pkg::*;

    ctl_state_t          state_reg, state_next;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;

    // State and step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CS_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            CS_IDLE:
            begin
                if (poll_valid)
                begin
                    state_next = stat.need_div ? CS_PREP : CS_PUSH;
                end
            end
            CS_PREP:
            begin
                state_next = CS_DIV;
            end
            CS_DIV:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = CS_PUSH;
                end
            end
            CS_PUSH:
            begin
                if (stat.out_free)
                begin
                    state_next = CS_IDLE;
                end
            end
            default:
            begin
                state_next = CS_IDLE;
            end
        endcase
    end

    // Outputs and divide step count
    always_comb
    begin
        cmd        = '0;
        poll_ready = 1'b0;
        cnt_next   = cnt_reg;
        case (state_reg)
            CS_IDLE:
            begin
                poll_ready = 1'b1;
                cmd.step   = poll_valid;
            end
            CS_PREP:
            begin
                cmd.prep = 1'b1;
                cnt_next = CNT_BITS'(DIV_STEPS - 1);
            end
            CS_DIV:
            begin
                cmd.div  = 1'b1;
                cnt_next = cnt_reg - CNT_BITS'(1);
            end
            CS_PUSH:
            begin
                cmd.push = stat.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

### sv/bsq_datapath.sv
// Datapath of the brew sequencer: configuration registers, phase state,
// poll step logic, restoring percentage divider and result register.
// Depends on bsq_pkg.
`timescale 1ns / 1ps

module bsq_datapath (
    input  logic                               clk,
    input  logic                               rst_n,
    input  bsq_pkg::poll_item_t                poll_data,
    input  logic                               cfg_valid,
    input  logic [bsq_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [bsq_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    input  bsq_pkg::bsq_cmd_t                  cmd,
    output bsq_pkg::bsq_stat_t                 stat,
    output logic                               res_valid,
    input  logic                               res_ready,
    output bsq_pkg::result_item_t              res_data
);
    import bsq_pkg::*;

    // Configuration registers
    logic [BREW_BITS-1:0]  filter_time_reg, espr_time_reg;
    logic [SLEEP_BITS-1:0] sleep_after_reg;
    logic [TEMP_BITS-1:0]  preheat_lvl_reg, brew_lvl_reg;

    // Sequencer state
    phase_t               phase_reg, phase_next;
    logic                 mode_reg, mode_next;
    logic                 heater_reg, heater_next;
    logic                 pump_reg, pump_next;
    logic [TIME_BITS-1:0] elapsed_reg, elapsed_next;
    logic                 done_reg, done_next;
    logic                 div_used_reg, div_used_next;

    // Divider
    logic [NUM_BITS-1:0]  rem_reg, rem_next;
    logic [NUM_BITS-1:0]  dsh_reg, dsh_next;
    logic [PCT_BITS-1:0]  quo_reg, quo_next;

    // Result register
    logic                 res_valid_reg, res_valid_next;
    result_item_t         res_data_reg, res_data_next;

    logic [TIME_BITS:0]   sum;
    logic [TIME_BITS-1:0] sat_time;
    logic [BREW_BITS-1:0] brew_time;
    logic [TIME_BITS-1:0] brew_elapsed;
    logic                 brew_heater;
    logic                 brew_running;
    logic                 need_div;
    logic                 quo_bit;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filter_time_reg <= FILTER_TIME_RST;
            espr_time_reg   <= ESPR_TIME_RST;
            sleep_after_reg <= SLEEP_AFTER_RST;
            preheat_lvl_reg <= PREHEAT_RST;
            brew_lvl_reg    <= BREW_LEVEL_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_FILTER_TIME: filter_time_reg <= cfg_data[BREW_BITS-1:0];
                REG_ESPR_TIME:   espr_time_reg   <= cfg_data[BREW_BITS-1:0];
                REG_SLEEP_AFTER: sleep_after_reg <= cfg_data[SLEEP_BITS-1:0];
                REG_PREHEAT_LVL: preheat_lvl_reg <= cfg_data[TEMP_BITS-1:0];
                REG_BREW_LVL:    brew_lvl_reg    <= cfg_data[TEMP_BITS-1:0];
                default:         filter_time_reg <= filter_time_reg;
            endcase
        end
    end

    // Saturating elapsed time and the mode's brew time
    always_comb
    begin
        sum       = {1'b0, elapsed_reg} + (TIME_BITS + 1)'(poll_data.delta_ms);
        sat_time  = sum[TIME_BITS] ? '1 : sum[TIME_BITS-1:0];
        brew_time = mode_reg ? espr_time_reg : filter_time_reg;
    end

    // Thermostat and time advance of a brewing poll
    always_comb
    begin
        brew_running = CMP_BITS'(elapsed_reg) < CMP_BITS'(brew_time);
        brew_elapsed = elapsed_reg;
        brew_heater  = heater_reg;
        if (brew_running)
        begin
            if (poll_data.temp_code < brew_lvl_reg)
            begin
                brew_heater = 1'b1;
            end
            else if (poll_data.temp_code > brew_lvl_reg)
            begin
                brew_heater = 1'b0;
            end
            brew_elapsed = sat_time;
        end
    end

    // Step the sequencer by one poll
    always_comb
    begin
        phase_next   = phase_reg;
        mode_next    = mode_reg;
        heater_next  = heater_reg;
        pump_next    = pump_reg;
        elapsed_next = elapsed_reg;
        done_next    = 1'b0;
        need_div     = 1'b0;
        case (phase_reg)
            PH_SELECT:
            begin
                if (poll_data.select_pressed)
                begin
                    phase_next   = PH_PREHEAT;
                    heater_next  = 1'b1;
                    elapsed_next = '0;
                end
                else
                begin
                    mode_next    = mode_reg ^ poll_data.switch_pressed;
                    elapsed_next = sat_time;
                    if (CMP_BITS'(sat_time) > CMP_BITS'(sleep_after_reg))
                    begin
                        phase_next = PH_ASLEEP;
                    end
                end
            end
            PH_PREHEAT, PH_COAST:
            begin
                if (phase_reg == PH_COAST || poll_data.temp_code >= preheat_lvl_reg)
                begin
                    heater_next = 1'b0;
                    phase_next  = PH_COAST;
                    if (poll_data.temp_code >= brew_lvl_reg)
                    begin
                        phase_next   = PH_BREW;
                        pump_next    = 1'b1;
                        elapsed_next = '0;
                    end
                end
            end
            PH_BREW:
            begin
                if (CMP_BITS'(brew_elapsed) >= CMP_BITS'(brew_time))
                begin
                    pump_next    = 1'b0;
                    heater_next  = 1'b0;
                    done_next    = 1'b1;
                    phase_next   = PH_SELECT;
                    elapsed_next = '0;
                end
                else
                begin
                    heater_next  = brew_heater;
                    elapsed_next = brew_elapsed;
                    need_div     = 1'b1;
                end
            end
            default:
            begin
                phase_next  = PH_ASLEEP;
                heater_next = 1'b0;
                pump_next   = 1'b0;
            end
        endcase
    end

    // Divider: load 100*elapsed over the shifted brew time, then one quotient bit a step
    always_comb
    begin
        rem_next = rem_reg;
        dsh_next = dsh_reg;
        quo_next = quo_reg;
        quo_bit  = rem_reg >= dsh_reg;
        if (cmd.prep)
        begin
            rem_next = NUM_BITS'(elapsed_reg) * NUM_BITS'(PCT_FULL);
            dsh_next = NUM_BITS'(brew_time) << (DIV_STEPS - 1);
            quo_next = '0;
        end
        else if (cmd.div)
        begin
            if (quo_bit)
            begin
                rem_next = rem_reg - dsh_reg;
            end
            dsh_next = dsh_reg >> 1;
            quo_next = {quo_reg[PCT_BITS-2:0], quo_bit};
        end
    end

    // Result register: load on push, drop when the beat is taken
    always_comb
    begin
        res_valid_next = res_valid_reg;
        res_data_next  = res_data_reg;
        if (res_valid_reg && res_ready)
        begin
            res_valid_next = 1'b0;
        end
        if (cmd.push)
        begin
            res_valid_next              = 1'b1;
            res_data_next.phase         = phase_reg;
            res_data_next.heater_on     = heater_reg;
            res_data_next.pump_on       = pump_reg;
            res_data_next.mode_espresso = mode_reg;
            res_data_next.brew_done     = done_reg;
            res_data_next.progress_pct  = done_reg     ? PCT_FULL :
                                          div_used_reg ? quo_reg  : '0;
        end
        div_used_next = cmd.step ? need_div : div_used_reg;
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_SELECT;
            mode_reg      <= 1'b0;
            heater_reg    <= 1'b0;
            pump_reg      <= 1'b0;
            elapsed_reg   <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.step)
            begin
                phase_reg   <= phase_next;
                mode_reg    <= mode_next;
                heater_reg  <= heater_next;
                pump_reg    <= pump_next;
                elapsed_reg <= elapsed_next;
            end
            res_valid_reg <= res_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.step)
        begin
            done_reg <= done_next;
        end
        div_used_reg <= div_used_next;
        rem_reg      <= rem_next;
        dsh_reg      <= dsh_next;
        quo_reg      <= quo_next;
        res_data_reg <= res_data_next;
    end

    assign stat.need_div = need_div;
    assign stat.out_free = !res_valid_reg || res_ready;
    assign res_valid     = res_valid_reg;
    assign res_data      = res_data_reg;

endmodule

### sv/brew_sequencer_with_thermostat.sv
// Brew sequencer with thermostat: one result beat for every poll beat. A poll
// outside brewing goes from idle to the push state, where its result is loaded
// into the result register; a brewing poll that does not finish first passes the
// restoring percentage divider: one set-up step and 7 steps of one quotient bit
// each, then the push state. A poll is taken only while the controller is idle,
// so the next one can be accepted in the cycle after the previous result has
// been loaded. A result left waiting in the result register stalls the following
// poll after its acceptance, and no further poll is taken until the waiting beat
// leaves.
// Configuration writes are taken every cycle and must only be made while idle.
// Depends on bsq_pkg, bsq_if, bsq_ctrl, bsq_datapath and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module brew_sequencer_with_thermostat (
    input  logic                clk,
    input  logic                rst_n,
    bsq_poll_if.sink            poll,
    bsq_result_if.source        result,
    bsq_cfg_if.sink             cfg
);
    import bsq_pkg::*;

    bsq_cmd_t  cmd;
    bsq_stat_t stat;
    logic      poll_ready;
    logic      done_ok;
    logic      pump_ok;
    logic      idle_beat;
    logic      pct_ok;

    assign poll.ready = poll_ready;
    assign cfg.ready  = 1'b1;

    // Sequence control
    bsq_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .poll_valid (poll.valid),
        .poll_ready (poll_ready),
        .stat       (stat),
        .cmd        (cmd)
    );

    // State, arithmetic and result register
    bsq_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .poll_data  (poll.data),
        .cfg_valid  (cfg.valid),
        .cfg_index  (cfg.index),
        .cfg_data   (cfg.data),
        .cmd        (cmd),
        .stat       (stat),
        .res_valid  (result.valid),
        .res_ready  (result.ready),
        .res_data   (result.data)
    );

    // Result field checks
    assign done_ok   = result.data.progress_pct == PCT_FULL && result.data.phase == PH_SELECT;
    assign pump_ok   = result.data.phase == PH_BREW;
    assign idle_beat = result.valid && !result.data.brew_done && result.data.phase != PH_BREW;
    assign pct_ok    = result.data.progress_pct == '0;

    `ASSERT_NEXT(a_one_poll_in_flight, clk, rst_n, poll.valid && poll_ready, !poll_ready)
    `ASSERT_IMPLIES(a_done_full, clk, rst_n, result.valid && result.data.brew_done, done_ok)
    `ASSERT_IMPLIES(a_pump_only_brewing, clk, rst_n, result.valid && result.data.pump_on, pump_ok)
    `ASSERT_IMPLIES(a_pct_zero_idle, clk, rst_n, idle_beat, pct_ok)

endmodule
